// ----- design/segment_intersection_point_assert.svh -----
// Assertion macros for the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_POINT_ASSERT_SVH
`define SEGMENT_INTERSECTION_POINT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property at each rising clock edge, skipped while reset is low.
`define SIP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check a property at each rising clock edge, reset included.
`define SIP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define SIP_ASSERT(lbl, clk, rst_n, prop)
`define SIP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- design/sip_pkg.sv -----
// Shared constants for the segment intersection block.
package sip_pkg;

  // Width of one coordinate field on the input channel.
  localparam int FIELD_W = 16;
  // Width of the intersection coordinates on the result channel.
  localparam int CROSS_W = 32;

endpackage

// ----- design/sip_seg_if.sv -----
// Input channel: one pair of segments per transfer.
interface sip_seg_if import sip_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] a_start_x;
  logic signed [FIELD_W-1:0] a_start_y;
  logic signed [FIELD_W-1:0] a_end_x;
  logic signed [FIELD_W-1:0] a_end_y;
  logic signed [FIELD_W-1:0] b_start_x;
  logic signed [FIELD_W-1:0] b_start_y;
  logic signed [FIELD_W-1:0] b_end_x;
  logic signed [FIELD_W-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

// ----- design/sip_res_if.sv -----
// Result channel: hit flag and intersection point per transfer.
interface sip_res_if import sip_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [CROSS_W-1:0] cross_x;
  logic signed [CROSS_W-1:0] cross_y;

  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

// ----- design/segment_intersection_point.sv -----
// Segment pair intersection by Cramer's rule, fully pipelined.
//
// seg_i carries one pair of segments per transfer (eight signed coordinates,
// low COORD_BITS bits used, sign-extended). res_o returns one result per
// pair: hit, and the truncated intersection point, which reads zero when
// hit is low (parallel lines, or point off either segment).
// The pipeline has six stages for the determinant and the numerators, one
// divider stage per quotient bit, two check stages and the output register.
// Throughput is one pair per cycle while the receiver does not stall; the
// divider's one-bit-per-stage chain sets the depth.
// Reset clears every valid bit; no result is pending after reset.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and seg_i.ready drops; no item is lost or repeated.
`include "segment_intersection_point_assert.svh"

module segment_intersection_point import sip_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sip_seg_if.sink  seg_i,
  sip_res_if.source res_o
);

  localparam int N    = COORD_BITS;
  localparam int NW   = 3 * N + 3;
  localparam int DETW = 2 * N + 3;
  localparam int SBW  = 8 * N + 3;

  logic                  en;
  logic [7:0][N-1:0]     crd_in, crd_f, crd_d;
  logic                  fv, dv, cv;
  logic [NW-1:0]         anx, any;
  logic [DETW-1:0]       adet;
  logic                  negx, negy, dz;
  logic [SBW-1:0]        sb_f, sb_d;
  logic [N-1:0]          qx, qy;
  logic                  ovf, hit;
  logic signed [N:0]     px, py;
  logic                  out_v_q, hit_q;
  logic signed [CROSS_W-1:0] cx_q, cy_q;

  // Advance everything unless a result waits on a stalled receiver
  assign en          = !out_v_q || res_o.ready;
  assign seg_i.ready = en;

  assign crd_in[0] = N'(seg_i.a_start_x);
  assign crd_in[1] = N'(seg_i.a_start_y);
  assign crd_in[2] = N'(seg_i.a_end_x);
  assign crd_in[3] = N'(seg_i.a_end_y);
  assign crd_in[4] = N'(seg_i.b_start_x);
  assign crd_in[5] = N'(seg_i.b_start_y);
  assign crd_in[6] = N'(seg_i.b_end_x);
  assign crd_in[7] = N'(seg_i.b_end_y);

  sip_front #(.N(N), .NW(NW), .DETW(DETW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (seg_i.valid && seg_i.ready),
    .crd_i   (crd_in),
    .valid_o (fv),
    .crd_o   (crd_f),
    .anx_o   (anx),
    .any_o   (any),
    .adet_o  (adet),
    .negx_o  (negx),
    .negy_o  (negy),
    .dz_o    (dz)
  );

  assign sb_f = {dz, negy, negx, crd_f};

  sip_div #(.N(N), .NW(NW), .DETW(DETW), .SBW(SBW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .anx_i   (anx),
    .any_i   (any),
    .adet_i  (adet),
    .sb_i    (sb_f),
    .valid_o (dv),
    .qx_o    (qx),
    .qy_o    (qy),
    .ovf_o   (ovf),
    .sb_o    (sb_d)
  );

  assign crd_d = sb_d[8*N-1:0];

  sip_check #(.N(N)) u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .qx_i    (qx),
    .qy_i    (qy),
    .ovf_i   (ovf),
    .negx_i  (sb_d[8*N]),
    .negy_i  (sb_d[8*N+1]),
    .dz_i    (sb_d[8*N+2]),
    .crd_i   (crd_d),
    .valid_o (cv),
    .hit_o   (hit),
    .px_o    (px),
    .py_o    (py)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= cv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit;
      cx_q  <= hit ? CROSS_W'(px) : '0;
      cy_q  <= hit ? CROSS_W'(py) : '0;
    end
  end

  assign res_o.valid   = out_v_q;
  assign res_o.hit     = hit_q;
  assign res_o.cross_x = cx_q;
  assign res_o.cross_y = cy_q;

  `SIP_ASSERT(a_miss_zero, clk_i, rst_ni, res_o.valid && !res_o.hit |-> res_o.cross_x == '0 && res_o.cross_y == '0)
  `SIP_ASSERT(a_hit_range, clk_i, rst_ni, res_o.valid && res_o.hit |-> (&res_o.cross_x[CROSS_W-1:N-1]) || !(|res_o.cross_x[CROSS_W-1:N-1]))
  `SIP_ASSERT(a_stall_hold, clk_i, rst_ni, res_o.valid && !res_o.ready |=> $stable({fv, dv, cv}))
  `SIP_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !res_o.valid)

endmodule

// ----- design/sip_front.sv -----
// Front pipeline: determinant and Cramer numerators, as magnitudes and signs.
module sip_front import sip_pkg::*; #(
  parameter int N    = 16,
  parameter int NW   = 3 * N + 3,
  parameter int DETW = 2 * N + 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [7:0][N-1:0]   crd_i,
  output logic                valid_o,
  output logic [7:0][N-1:0]   crd_o,
  output logic [NW-1:0]       anx_o,
  output logic [NW-1:0]       any_o,
  output logic [DETW-1:0]     adet_o,
  output logic                negx_o,
  output logic                negy_o,
  output logic                dz_o
);

  localparam int DW  = N + 1;
  localparam int CPW = 2 * N;
  localparam int CAW = 2 * N + 1;
  localparam int PW  = 2 * N + 2;
  localparam int NPW = 3 * N + 2;

  logic [5:0]               v_q;
  logic [7:0][N-1:0]        c0_q, c1_q, c2_q, c3_q, c4_q, c5_q;
  logic signed [N-1:0]      x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [DW-1:0]     dxa1_q, dya1_q, dxb1_q, dyb1_q;
  logic signed [CPW-1:0]    ca1_q, ca2_q, cb1_q, cb2_q;
  logic signed [DW-1:0]     dxa2_q, dya2_q, dxb2_q, dyb2_q;
  logic signed [PW-1:0]     pa_q, pb_q;
  logic signed [CAW-1:0]    ca_q, cb_q;
  logic signed [DETW-1:0]   det3_q, det4_q;
  logic signed [NPW-1:0]    m1_q, m2_q, m3_q, m4_q;
  logic signed [NW-1:0]     nx_q, ny_q;
  logic [NW-1:0]            anx_q, any_q;
  logic [DETW-1:0]          adet_q;
  logic                     negx_q, negy_q, dz_q;

  assign x1 = c0_q[0];
  assign y1 = c0_q[1];
  assign x2 = c0_q[2];
  assign y2 = c0_q[3];
  assign x3 = c0_q[4];
  assign y3 = c0_q[5];
  assign x4 = c0_q[6];
  assign y4 = c0_q[7];

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Capture coordinates
      c0_q <= crd_i;
      // Edge vectors and cross terms of the endpoints
      c1_q   <= c0_q;
      dxa1_q <= DW'(x1) - DW'(x2);
      dya1_q <= DW'(y1) - DW'(y2);
      dxb1_q <= DW'(x3) - DW'(x4);
      dyb1_q <= DW'(y3) - DW'(y4);
      ca1_q  <= CPW'(x1) * CPW'(y2);
      ca2_q  <= CPW'(y1) * CPW'(x2);
      cb1_q  <= CPW'(x3) * CPW'(y4);
      cb2_q  <= CPW'(y3) * CPW'(x4);
      // Determinant products and line constants
      c2_q   <= c1_q;
      dxa2_q <= dxa1_q;
      dya2_q <= dya1_q;
      dxb2_q <= dxb1_q;
      dyb2_q <= dyb1_q;
      pa_q   <= PW'(dxa1_q) * PW'(dyb1_q);
      pb_q   <= PW'(dya1_q) * PW'(dxb1_q);
      ca_q   <= CAW'(ca1_q) - CAW'(ca2_q);
      cb_q   <= CAW'(cb1_q) - CAW'(cb2_q);
      // Determinant and numerator products
      c3_q   <= c2_q;
      det3_q <= DETW'(pa_q) - DETW'(pb_q);
      m1_q   <= NPW'(ca_q) * NPW'(dxb2_q);
      m2_q   <= NPW'(dxa2_q) * NPW'(cb_q);
      m3_q   <= NPW'(ca_q) * NPW'(dyb2_q);
      m4_q   <= NPW'(dya2_q) * NPW'(cb_q);
      // Numerators
      c4_q   <= c3_q;
      det4_q <= det3_q;
      nx_q   <= NW'(m1_q) - NW'(m2_q);
      ny_q   <= NW'(m3_q) - NW'(m4_q);
      // Split into magnitude and quotient sign
      c5_q   <= c4_q;
      anx_q  <= nx_q[NW-1] ? -nx_q : nx_q;
      any_q  <= ny_q[NW-1] ? -ny_q : ny_q;
      adet_q <= det4_q[DETW-1] ? -det4_q : det4_q;
      negx_q <= nx_q[NW-1] ^ det4_q[DETW-1];
      negy_q <= ny_q[NW-1] ^ det4_q[DETW-1];
      dz_q   <= (det4_q == '0);
    end
  end

  assign valid_o = v_q[5];
  assign crd_o   = c5_q;
  assign anx_o   = anx_q;
  assign any_o   = any_q;
  assign adet_o  = adet_q;
  assign negx_o  = negx_q;
  assign negy_o  = negy_q;
  assign dz_o    = dz_q;

endmodule

// ----- design/sip_div.sv -----
// Pipelined restoring divider: two numerators over one divisor, one bit per stage.
module sip_div import sip_pkg::*; #(
  parameter int N    = 16,
  parameter int NW   = 3 * N + 3,
  parameter int DETW = 2 * N + 3,
  parameter int SBW  = 8 * N + 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NW-1:0]   anx_i,
  input  logic [NW-1:0]   any_i,
  input  logic [DETW-1:0] adet_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            valid_o,
  output logic [N-1:0]    qx_o,
  output logic [N-1:0]    qy_o,
  output logic            ovf_o,
  output logic [SBW-1:0]  sb_o
);

  logic [N-1:0]    v_q;
  logic [NW-1:0]   rx_q  [N];
  logic [NW-1:0]   ry_q  [N];
  logic [N-1:0]    qx_q  [N];
  logic [N-1:0]    qy_q  [N];
  logic [DETW-1:0] d_q   [N];
  logic            ovf_q [N];
  logic [SBW-1:0]  sb_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [NW-1:0]   rx_in, ry_in, dv_sh;
    logic [DETW-1:0] d_in;
    logic [N-1:0]    qx_in, qy_in;
    logic            ovf_in, v_in, gx, gy;
    logic [SBW-1:0]  sb_in;

    if (k == 0) begin : g_first
      // Quotient needs more than N bits: no point on either segment
      assign ovf_in = ({1'b0, anx_i} >= ((NW + 1)'(adet_i) << N)) ||
                      ({1'b0, any_i} >= ((NW + 1)'(adet_i) << N));
      assign rx_in  = anx_i;
      assign ry_in  = any_i;
      assign d_in   = adet_i;
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign v_in   = valid_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign ovf_in = ovf_q[k-1];
      assign rx_in  = rx_q[k-1];
      assign ry_in  = ry_q[k-1];
      assign d_in   = d_q[k-1];
      assign qx_in  = qx_q[k-1];
      assign qy_in  = qy_q[k-1];
      assign v_in   = v_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    // Trial subtract of the divisor at this bit weight
    assign dv_sh = NW'(d_in) << (N - 1 - k);
    assign gx    = (rx_in >= dv_sh);
    assign gy    = (ry_in >= dv_sh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k]  <= gx ? rx_in - dv_sh : rx_in;
        ry_q[k]  <= gy ? ry_in - dv_sh : ry_in;
        qx_q[k]  <= {qx_in[N-2:0], gx};
        qy_q[k]  <= {qy_in[N-2:0], gy};
        d_q[k]   <= d_in;
        ovf_q[k] <= ovf_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign qx_o    = qx_q[N-1];
  assign qy_o    = qy_q[N-1];
  assign ovf_o   = ovf_q[N-1];
  assign sb_o    = sb_q[N-1];

endmodule

// ----- design/sip_check.sv -----
// Back pipeline: signed point and the on-segment distance test.
module sip_check import sip_pkg::*; #(
  parameter int N = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [N-1:0]      qx_i,
  input  logic [N-1:0]      qy_i,
  input  logic              ovf_i,
  input  logic              negx_i,
  input  logic              negy_i,
  input  logic              dz_i,
  input  logic [7:0][N-1:0] crd_i,
  output logic              valid_o,
  output logic              hit_o,
  output logic signed [N:0] px_o,
  output logic signed [N:0] py_o
);

  localparam int AW = N + 2;
  localparam int SW = N + 4;

  function automatic logic [AW-1:0] absdiff(input logic signed [N:0] a,
                                            input logic signed [N:0] b);
    logic signed [AW-1:0] d;
    d = AW'(a) - AW'(b);
    return d[AW-1] ? -d : d;
  endfunction

  logic [1:0]               v_q;
  logic signed [N:0]        px0_q, py0_q, px1_q, py1_q;
  logic                     ok0_q, ok1_q;
  logic [7:0][N-1:0]        c0_q;
  logic signed [N:0]        cs [8];
  logic [11:0][AW-1:0]      ad_q;
  logic                     on_a, on_b;

  for (genvar i = 0; i < 8; i++) begin : g_crd
    assign cs[i] = (N + 1)'($signed(c0_q[i]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Apply the quotient sign
      px0_q <= negx_i ? -$signed({1'b0, qx_i}) : $signed({1'b0, qx_i});
      py0_q <= negy_i ? -$signed({1'b0, qy_i}) : $signed({1'b0, qy_i});
      ok0_q <= !dz_i && !ovf_i;
      c0_q  <= crd_i;
      // Manhattan distance components for both segments
      px1_q    <= px0_q;
      py1_q    <= py0_q;
      ok1_q    <= ok0_q;
      ad_q[0]  <= absdiff(cs[0], px0_q);
      ad_q[1]  <= absdiff(cs[1], py0_q);
      ad_q[2]  <= absdiff(cs[2], px0_q);
      ad_q[3]  <= absdiff(cs[3], py0_q);
      ad_q[4]  <= absdiff(cs[0], cs[2]);
      ad_q[5]  <= absdiff(cs[1], cs[3]);
      ad_q[6]  <= absdiff(cs[4], px0_q);
      ad_q[7]  <= absdiff(cs[5], py0_q);
      ad_q[8]  <= absdiff(cs[6], px0_q);
      ad_q[9]  <= absdiff(cs[7], py0_q);
      ad_q[10] <= absdiff(cs[4], cs[6]);
      ad_q[11] <= absdiff(cs[5], cs[7]);
    end
  end

  // Point lies on a segment when the two distances add up to its length
  assign on_a = (SW'(ad_q[0]) + SW'(ad_q[1]) + SW'(ad_q[2]) + SW'(ad_q[3])) ==
                (SW'(ad_q[4]) + SW'(ad_q[5]));
  assign on_b = (SW'(ad_q[6]) + SW'(ad_q[7]) + SW'(ad_q[8]) + SW'(ad_q[9])) ==
                (SW'(ad_q[10]) + SW'(ad_q[11]));

  assign valid_o = v_q[1];
  assign hit_o   = ok1_q && on_a && on_b;
  assign px_o    = px1_q;
  assign py_o    = py1_q;

endmodule

// ----- sim/tb_segment_intersection_point.sv -----
// Testbench for segment_intersection_point: random and directed segment pairs
// against a predictor of the intersection point.
module tb_segment_intersection_point;
  import sip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 16;
  localparam int LATENCY    = COORD_BITS + 9;
  localparam int IDLE_LIMIT = 20000;
  localparam int NUM_RANDOM = 1650;

  typedef struct packed {
    logic signed [FIELD_W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  } seg_pair_t;

  typedef struct packed {
    logic                      hit;
    logic signed [CROSS_W-1:0] px;
    logic signed [CROSS_W-1:0] py;
  } crossing_t;

  logic clk_i;
  logic rst_ni;

  sip_seg_if seg_if ();
  sip_res_if res_if ();

  segment_intersection_point #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .seg_i (seg_if.sink),
    .res_o (res_if.source)
  );

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int        errors;
  int        hits_seen;
  int        results_seen;
  int        idle_cycles;
  bit        stimulus_done;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint coord(logic signed [FIELD_W-1:0] v);
    logic [COORD_BITS-1:0] low;
    low = v[COORD_BITS-1:0];
    return longint'($signed(low));
  endfunction

  function automatic longint absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit lies_on(longint px, longint py, longint sx, longint sy,
                                 longint ex, longint ey);
    return absval(sx - px) + absval(sy - py) + absval(ex - px) + absval(ey - py)
           == absval(sx - ex) + absval(sy - ey);
  endfunction

  // Predict the crossing of one pair
  function automatic crossing_t predict_crossing(seg_pair_t s);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint det, ca, cb, nx, ny, px, py;
    crossing_t r;
    x1 = coord(s.ax1); y1 = coord(s.ay1); x2 = coord(s.ax2); y2 = coord(s.ay2);
    x3 = coord(s.bx1); y3 = coord(s.by1); x4 = coord(s.bx2); y4 = coord(s.by2);
    r = '0;
    det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    if (det == 0) return r;
    ca = x1 * y2 - y1 * x2;
    cb = x3 * y4 - y3 * x4;
    nx = ca * (x3 - x4) - (x1 - x2) * cb;
    ny = ca * (y3 - y4) - (y1 - y2) * cb;
    px = nx / det;
    py = ny / det;
    if (lies_on(px, py, x1, y1, x2, y2) && lies_on(px, py, x3, y3, x4, y4)) begin
      r.hit = 1'b1;
      r.px  = px[CROSS_W-1:0];
      r.py  = py[CROSS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_coord(int mode);
    case (mode)
      0: return FIELD_W'($urandom);
      1: return FIELD_W'($signed($urandom_range(0, 64)) - 32);
      default: return FIELD_W'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // Build a pair likely to cross: in two of three cases B passes through a point on A
  function automatic seg_pair_t crossing_pair(int mode);
    seg_pair_t s;
    int k;
    s.ax1 = rand_coord(mode); s.ay1 = rand_coord(mode);
    s.ax2 = rand_coord(mode); s.ay2 = rand_coord(mode);
    k = $urandom_range(0, 2);
    s.bx1 = rand_coord(mode); s.by1 = rand_coord(mode);
    case (k)
      0: begin
        s.bx2 = s.ax1 + s.ax1 - s.bx1;
        s.by2 = s.ay1 + s.ay1 - s.by1;
      end
      1: begin
        s.bx2 = (s.ax1 >>> 1) + (s.ax2 >>> 1);
        s.by2 = (s.ay1 >>> 1) + (s.ay2 >>> 1);
        s.bx2 = s.bx2 + s.bx2 - s.bx1;
        s.by2 = s.by2 + s.by2 - s.by1;
      end
      default: begin
        s.bx2 = rand_coord(mode); s.by2 = rand_coord(mode);
      end
    endcase
    return s;
  endfunction

  // Fill the stimulus queue
  initial begin
    seg_pair_t s;
    logic signed [FIELD_W-1:0] mx, mn;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    // Crossing at origin, parallel, collinear, degenerate, touching ends, off segment
    pending_pairs.push_back({-16'sd4, 16'sd0, 16'sd4, 16'sd0, 16'sd0, -16'sd4, 16'sd0, 16'sd4});
    pending_pairs.push_back({16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd0, 16'sd1, 16'sd5, 16'sd6});
    pending_pairs.push_back({16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd1, 16'sd1, 16'sd9, 16'sd9});
    pending_pairs.push_back({16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd0, 16'sd0, 16'sd7, 16'sd1});
    pending_pairs.push_back({16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd4, 16'sd0, 16'sd4, 16'sd9});
    pending_pairs.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd5, -16'sd3, 16'sd5, 16'sd3});
    pending_pairs.push_back({16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd0, 16'sd2, 16'sd3, 16'sd0});
    pending_pairs.push_back({-16'sd7, -16'sd1, 16'sd2, 16'sd3, 16'sd1, -16'sd5, -16'sd3, 16'sd6});
    // Extremes
    pending_pairs.push_back({mn, mn, mx, mx, mn, mx, mx, mn});
    pending_pairs.push_back({mn, 16'sd0, mx, 16'sd0, 16'sd0, mn, 16'sd0, mx});
    pending_pairs.push_back({mx, mx, mn, mn, mx, mn, mn, mx});
    pending_pairs.push_back({mn, mn, mn, mx, mx, mn, mn, mn});
    pending_pairs.push_back({mx, mn, mn, mx, mn, mn, mx, mx - 16'sd1});
    pending_pairs.push_back({16'shffff, 16'shffff, 16'shffff, 16'shffff,
                             16'shffff, 16'shffff, 16'shffff, 16'shffff});
    pending_pairs.push_back({16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
                             16'sh5555, 16'sh5555, 16'shaaaa, 16'shaaaa});
    pending_pairs.push_back('0);
    // Random: mostly crossing-shaped pairs, some pure noise
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        s = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
      end else begin
        s = crossing_pair($urandom_range(0, 2));
      end
      pending_pairs.push_back(s);
    end
  end

  // Drive the input channel; the front of the queue is the item on the bus
  int send_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_if.valid <= 1'b0;
      {seg_if.a_start_x, seg_if.a_start_y, seg_if.a_end_x, seg_if.a_end_y,
       seg_if.b_start_x, seg_if.b_start_y, seg_if.b_end_x, seg_if.b_end_y} <= '0;
      send_wait <= 0;
    end else begin
      if (seg_if.valid && seg_if.ready) begin
        expected_crossings.push_back(predict_crossing(pending_pairs.pop_front()));
      end
      if (!seg_if.valid || seg_if.ready) begin
        if (send_wait > 0) begin
          send_wait    <= send_wait - 1;
          seg_if.valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          seg_pair_t nxt;
          nxt = pending_pairs[0];
          seg_if.valid <= 1'b1;
          {seg_if.a_start_x, seg_if.a_start_y, seg_if.a_end_x, seg_if.a_end_y,
           seg_if.b_start_x, seg_if.b_start_y, seg_if.b_end_x, seg_if.b_end_y} <= nxt;
          send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        end else begin
          seg_if.valid <= 1'b0;
        end
      end
    end
  end

  // Check the result channel
  int recv_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_wait    <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        crossing_t got, want;
        got = {res_if.hit, res_if.cross_x, res_if.cross_y};
        results_seen++;
        if (expected_crossings.size() == 0) begin
          $display("%0t: unexpected result hit=%0b x=%0d y=%0d",
                   $time, got.hit, got.px, got.py);
          errors++;
        end else begin
          want = expected_crossings.pop_front();
          if (got.hit) hits_seen++;
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            errors++;
          end
          if (got.px !== want.px) begin
            $display("%0t: cross_x expected %0d actual %0d", $time, want.px, got.px);
            errors++;
          end
          if (got.py !== want.py) begin
            $display("%0t: cross_y expected %0d actual %0d", $time, want.py, got.py);
            errors++;
          end
        end
      end
      // Stall the receiver at random, with long stretches of no stall
      if (recv_wait > 0) begin
        recv_wait    <= recv_wait - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (res_if.valid && res_if.ready)
          recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      end
    end
  end

  // Watchdog on transfers
  always @(posedge clk_i) begin
    if (!rst_ni || (seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Reset, wait for drain, report
  initial begin
    errors = 0;
    hits_seen = 0;
    results_seen = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        wait (pending_pairs.size() == 0 && expected_crossings.size() == 0);
        repeat (LATENCY + 20) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: timeout with %0d results outstanding", $time,
                 expected_crossings.size());
        $display("segment_intersection_point test failed");
        $finish;
      end
    join_any
    $display("Checked %0d segment pairs, %0d of them crossing on both segments.",
             results_seen, hits_seen);
    if (errors == 0) begin
      $display("segment_intersection_point test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("segment_intersection_point test failed");
    end
    $finish;
  end

endmodule
